// ===== rtl/core/wrrn_pkg.sv =====
// ----------------------------------------------------------------------------
// wrrn_pkg
// Shared types and constants for the weighted residual RMS norm unit.
// ----------------------------------------------------------------------------
package wrrn_pkg;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int COEF_W   = 16;
   localparam int ACTIVE_W = 3;
   localparam int SUM_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int PROD_W   = 2 * VALUE_W;

   // vector length and component limits
   localparam int MAX_LENGTH       = 65536;
   localparam int NUM_COMPONENTS   = 4;
   localparam int INPUT_COMPONENTS = 4;
   localparam int COMP_LIMIT       = (NUM_COMPONENTS < INPUT_COMPONENTS) ?
                                     NUM_COMPONENTS : INPUT_COMPONENTS;
   localparam int COMP_IDX_W       = $clog2(INPUT_COMPONENTS);
   localparam int COMP_CNT_W       = $clog2(COMP_LIMIT + 1);
   localparam int COUNT_W          = $clog2(MAX_LENGTH + 1);

   // weighted sum accumulator: Q24.28, a few guard bits over the product sum
   localparam int ACC_W       = VALUE_W + COEF_W + $clog2(INPUT_COMPONENTS) + 2;
   localparam int ROUND_SHIFT = 12;
   localparam int SHIFTED_W   = ACC_W - ROUND_SHIFT;

   // divide and square root sequencing
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);
   localparam int REM_W      = ROOT_W + 2;
   localparam int CMP_W      = REM_W + 2;

   // configuration register indexes
   localparam logic [2:0] CSR_COEF_A = 3'd0;
   localparam logic [2:0] CSR_COEF_B = 3'd1;
   localparam logic [2:0] CSR_COEF_C = 3'd2;
   localparam logic [2:0] CSR_COEF_D = 3'd3;
   localparam logic [2:0] CSR_ACTIVE = 3'd4;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_a;
      logic signed [VALUE_W-1:0] value_b;
      logic signed [VALUE_W-1:0] value_c;
      logic signed [VALUE_W-1:0] value_d;
      logic                      is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] residual;
      logic                      saturated;
      logic [ROOT_W-1:0]         rms_norm;
      logic                      norm_valid;
   } rsp_payload_type;

   // control of the shared multiply-accumulate datapath
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

   // top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROUND,
      ST_SQUARE,
      ST_ACCUM,
      ST_NSTART,
      ST_NWAIT,
      ST_DONE
   } top_state_type;

   // divide / square root sequencer
   typedef enum logic [1:0] {
      DS_IDLE,
      DS_DIV,
      DS_SQRT,
      DS_DONE
   } ds_state_type;

endpackage

// ===== rtl/core/wrrn_mac.sv =====
// ----------------------------------------------------------------------------
// wrrn_mac
// Shared signed multiplier with product register, weighted sum accumulator
// and Q24.28 to Q16.16 rounding with saturation.
// ----------------------------------------------------------------------------
module wrrn_mac (
   input  logic                               clock,
   input  wrrn_pkg::mac_ctrl_type             ctrl,
   input  logic signed [wrrn_pkg::VALUE_W-1:0] mul_a,
   input  logic signed [wrrn_pkg::VALUE_W-1:0] mul_b,
   output logic signed [wrrn_pkg::PROD_W-1:0]  prod,
   output logic signed [wrrn_pkg::VALUE_W-1:0] residual,
   output logic                               res_sat
);
   import wrrn_pkg::*;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     acc_in;
   logic signed [ACC_W-1:0]     biased;
   logic signed [SHIFTED_W-1:0] shifted;
   logic                        over_hi;
   logic                        over_lo;

   // one multiply per cycle while mul_en is set, registered before any use
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // accumulate registered products
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // add half an lsb, floor by arithmetic shift, then clamp to 32 bits
   always_comb begin
      biased  = acc_ff + ACC_W'(1 << (ROUND_SHIFT - 1));
      shifted = biased[ACC_W-1:ROUND_SHIFT];
      over_hi = !shifted[SHIFTED_W-1] && (|shifted[SHIFTED_W-2:VALUE_W-1]);
      over_lo = shifted[SHIFTED_W-1] && !(&shifted[SHIFTED_W-2:VALUE_W-1]);
      if (over_hi) begin
         residual = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (over_lo) begin
         residual = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         residual = shifted[VALUE_W-1:0];
      end
      res_sat = over_hi || over_lo;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/wrrn_divsqrt.sv =====
// ----------------------------------------------------------------------------
// wrrn_divsqrt
// Bit-serial 64 by 17 bit divide followed by a two-bits-per-step integer
// square root; both phases share one compare and subtract unit.
// ----------------------------------------------------------------------------
module wrrn_divsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wrrn_pkg::SUM_W-1:0]    dividend,
   input  logic [wrrn_pkg::COUNT_W-1:0]  divisor,
   output logic                          done,
   output logic [wrrn_pkg::ROOT_W-1:0]   root
);
   import wrrn_pkg::*;

   ds_state_type          state_ff;
   ds_state_type          state_in;
   logic [SUM_W-1:0]      work_ff;
   logic [COUNT_W-1:0]    divisor_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;

   logic                  load;
   logic                  div_step;
   logic                  sqrt_step;
   logic                  div_last;
   logic                  sqrt_last;
   logic [CMP_W-1:0]      cmp_a;
   logic [CMP_W-1:0]      cmp_b;
   logic [CMP_W:0]        diff;
   logic                  ge;

   assign div_last  = (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1));
   assign sqrt_last = (cnt_ff == STEP_CNT_W'(SQRT_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DS_IDLE: if (start) state_in = DS_DIV;
         DS_DIV:  if (div_last) state_in = DS_SQRT;
         DS_SQRT: if (sqrt_last) state_in = DS_DONE;
         DS_DONE: state_in = DS_IDLE;
         default: state_in = DS_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      load      = 1'b0;
      div_step  = 1'b0;
      sqrt_step = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         DS_IDLE: load = start;
         DS_DIV:  div_step = 1'b1;
         DS_SQRT: sqrt_step = 1'b1;
         DS_DONE: done = 1'b1;
         default: done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // shared compare and subtract: restoring divide or root trial
   always_comb begin
      if (state_ff == DS_SQRT) begin
         cmp_a = {rem_ff, work_ff[SUM_W-1:SUM_W-2]};
         cmp_b = {2'b00, root_ff, 2'b01};
      end else begin
         cmp_a = {{(CMP_W-COUNT_W-1){1'b0}}, rem_ff[COUNT_W-1:0], work_ff[SUM_W-1]};
         cmp_b = {{(CMP_W-COUNT_W){1'b0}}, divisor_ff};
      end
      diff = {1'b0, cmp_a} - {1'b0, cmp_b};
      ge   = !diff[CMP_W];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load) begin
         work_ff    <= dividend;
         divisor_ff <= divisor;
         rem_ff     <= '0;
         root_ff    <= '0;
         cnt_ff     <= '0;
      end else if (div_step) begin
         work_ff <= {work_ff[SUM_W-2:0], ge};
         if (div_last) begin
            rem_ff <= '0;
            cnt_ff <= '0;
         end else begin
            rem_ff <= ge ? REM_W'(diff[COUNT_W-1:0]) : REM_W'(cmp_a[COUNT_W-1:0]);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end else if (sqrt_step) begin
         work_ff <= {work_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= ge ? diff[REM_W-1:0] : cmp_a[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign root = root_ff;

endmodule

// ===== rtl/core/weighted_residual_rms_norm_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_residual_rms_norm_unit
// Each item: the n active components (1..4) are weighted on the single
// shared multiplier, then rounded, squared and summed; the item marked
// last also runs the divide (64 steps) and square root (32 steps). A new
// item is accepted only after the previous one is handed to the output
// register, which frees the input side. Reset clears the sequencer, sums,
// counts, output valid, coefficients to zero and active_components to one.
// ----------------------------------------------------------------------------
module weighted_residual_rms_norm_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  wrrn_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wrrn_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata
);
   import wrrn_pkg::*;

   top_state_type             state_ff;
   top_state_type             state_in;

   logic signed [COEF_W-1:0]  coef_ff [INPUT_COMPONENTS];
   logic [ACTIVE_W-1:0]       active_ff;
   logic signed [VALUE_W-1:0] val_ff [INPUT_COMPONENTS];
   logic                      last_ff;
   logic [COMP_CNT_W-1:0]     k_ff;
   logic [COMP_CNT_W-1:0]     n_eff;
   logic                      prod_vld_ff;
   logic signed [VALUE_W-1:0] res_ff;
   logic                      res_sat_ff;
   logic [SUM_W-1:0]          ssum_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      ovf_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_payload_type           rsp_data_ff;

   logic                      accept;
   logic                      out_free;
   mac_ctrl_type              mac_ctrl;
   logic                      use_square;
   logic                      ds_start;
   logic                      ds_done;
   logic [ROOT_W-1:0]         ds_root;
   logic signed [VALUE_W-1:0] mul_a;
   logic signed [VALUE_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [VALUE_W-1:0] residual;
   logic                      res_sat;
   logic [SUM_W:0]            sum_wide;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < INPUT_COMPONENTS; i++) begin
            coef_ff[i] <= '0;
         end
         active_ff <= ACTIVE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_A: coef_ff[0] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_B: coef_ff[1] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_C: coef_ff[2] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_D: coef_ff[3] <= csr_wdata[COEF_W-1:0];
            CSR_ACTIVE: active_ff  <= csr_wdata[ACTIVE_W-1:0];
            default:    active_ff  <= active_ff;
         endcase
      end
   end

   // clamp the active component count into 1..limit
   always_comb begin
      if (active_ff == '0) begin
         n_eff = COMP_CNT_W'(1);
      end else if (32'(active_ff) > COMP_LIMIT) begin
         n_eff = COMP_CNT_W'(COMP_LIMIT);
      end else begin
         n_eff = COMP_CNT_W'(active_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MAC;
         ST_MAC:    if (k_ff == n_eff && !prod_vld_ff) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = last_ff ? ST_NSTART : ST_DONE;
         ST_NSTART: state_in = ST_NWAIT;
         ST_NWAIT:  if (ds_done) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mac_ctrl   = '0;
      use_square = 1'b0;
      ds_start   = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            mac_ctrl.clear = 1'b1;
         end
         ST_MAC: begin
            mac_ctrl.mul_en = (k_ff < n_eff);
            mac_ctrl.acc_en = prod_vld_ff;
         end
         ST_SQUARE: begin
            mac_ctrl.mul_en = 1'b1;
            use_square      = 1'b1;
         end
         ST_NSTART: ds_start = 1'b1;
         default:   ds_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // multiplier operand select: component times weight, or residual squared
   always_comb begin
      if (use_square) begin
         mul_a = res_ff;
         mul_b = res_ff;
      end else begin
         mul_a = val_ff[k_ff[COMP_IDX_W-1:0]];
         mul_b = VALUE_W'(coef_ff[k_ff[COMP_IDX_W-1:0]]);
      end
   end

   wrrn_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .prod     (prod),
      .residual (residual),
      .res_sat  (res_sat)
   );

   wrrn_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ds_start),
      .dividend (ssum_ff),
      .divisor  (count_ff),
      .done     (ds_done),
      .root     (ds_root)
   );

   // input capture and component stepping
   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff[0] <= req_payload.value_a;
         val_ff[1] <= req_payload.value_b;
         val_ff[2] <= req_payload.value_c;
         val_ff[3] <= req_payload.value_d;
         last_ff   <= req_payload.is_last;
      end
      if (state_ff == ST_ROUND) begin
         res_ff     <= residual;
         res_sat_ff <= res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         prod_vld_ff <= 1'b0;
      end else if (state_ff == ST_MAC) begin
         prod_vld_ff <= mac_ctrl.mul_en;
         if (mac_ctrl.mul_en) begin
            k_ff <= k_ff + 1'b1;
         end
      end else begin
         k_ff        <= '0;
         prod_vld_ff <= 1'b0;
      end
   end

   // saturating square sum and element count
   assign sum_wide = {1'b0, ssum_ff} + {1'b0, prod[SUM_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ssum_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (state_ff == ST_ACCUM) begin
         if (sum_wide[SUM_W]) begin
            ssum_ff <= '1;
            ovf_ff  <= 1'b1;
         end else begin
            ssum_ff <= sum_wide[SUM_W-1:0];
         end
         if (32'(count_ff) < MAX_LENGTH) begin
            count_ff <= count_ff + 1'b1;
         end
      end else if (state_ff == ST_DONE && out_free && last_ff) begin
         ssum_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff.residual   <= res_ff;
         rsp_data_ff.saturated  <= res_sat_ff || ovf_ff;
         rsp_data_ff.rms_norm   <= last_ff ? ds_root : '0;
         rsp_data_ff.norm_valid <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // the element count never passes the length limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_LENGTH)
      else $error("element count beyond limit");

   // an overflowed square sum is pinned at full scale
   a_ovf_pinned: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (ssum_ff == '1))
      else $error("square sum overflow flag without full-scale sum");

   // divide/root completion only while the sequencer waits for it
   a_ds_done_wait: assert property (@(posedge clock) disable iff (reset)
      ds_done |-> (state_ff == ST_NWAIT))
      else $error("divide/root finished outside wait state");

   // a result without norm carries a zero norm
   a_norm_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.norm_valid) |-> (rsp_payload.rms_norm == '0))
      else $error("rms norm nonzero on a non-last transfer");

endmodule
